[hdl/hrgb_pkg.sv]
// Shared constants, widths and the hue segment weight for the HSL to RGB converter.
// No dependencies; imported by the converter top level.
`default_nettype none

package hrgb_pkg;

  // Field and intermediate widths.
  localparam int unsigned HUE_W = 13;
  localparam int unsigned PCT_W = 14;
  localparam int unsigned K_W   = 10;  // segment weight, 0..960
  localparam int unsigned M_W   = 13;  // min(L, full - L), 0..6400
  localparam int unsigned E_W   = 27;  // S * min(L, full - L)
  localparam int unsigned P_W   = 28;  // p and L * full
  localparam int unsigned W_W   = 37;  // per-channel numerator before scaling

  // Hue points, in 1/16 degree.
  localparam logic [HUE_W-1:0] HUE_TURN       = 13'd5760;
  localparam logic [HUE_W-1:0] HUE_THIRD      = 13'd1920;
  localparam logic [HUE_W-1:0] HUE_SIXTH      = 13'd960;
  localparam logic [HUE_W-1:0] HUE_HALF       = 13'd2880;
  localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 13'd3840;

  // Percent scale, 1/128 percent.
  localparam logic [PCT_W-1:0] PCT_FULL = 14'd12800;
  localparam logic [PCT_W-1:0] PCT_HALF = 14'd6400;

  // Weight of p in the channel numerator (half of one sixth turn).
  localparam logic [9:0] P_WEIGHT = 10'd480;

  // Channel scaling: result = floor((w * full_scale + 2^22 * 9375) / (2^23 * 9375)).
  localparam int unsigned     RGB_SHIFT = 23;
  localparam int unsigned     RGB_DIV   = 9375;
  localparam int unsigned     RGB_REM_W = 14;
  localparam logic [W_W-1:0]  RGB_RND   = 37'd39321600000;

  // Opacity scaling: result = floor((a * full_scale + 6400) / (2^9 * 25)).
  localparam int unsigned A_SHIFT = 9;
  localparam int unsigned A_DIV   = 25;
  localparam int unsigned A_REM_W = 5;

  // Quotient bits resolved per divider pipeline stage.
  localparam int unsigned DIV_STEPS = 4;

  // Piecewise weight k of (q - p) for a wrapped hue fraction t.
  function automatic logic [K_W-1:0] seg_weight(input logic [HUE_W-1:0] t);
    logic [HUE_W-1:0] r;
    if (t < HUE_SIXTH) begin
      r = t;
    end else if (t < HUE_HALF) begin
      r = HUE_SIXTH;
    end else if (t < HUE_TWO_THIRDS) begin
      r = HUE_TWO_THIRDS - t;
    end else begin
      r = '0;
    end
    return r[K_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/hsl_to_rgb_convert_unit.sv]
// HSLA to RGBA pixel converter, top level with its full pipeline.
// Depends on hrgb_pkg and hrgb_cdiv_step.
//
// Takes one pixel request per clock and returns one per clock with no gaps while
// out_ready_i stays high. Each request passes the four front stages, then the
// divider stages, which do the rounding division by 9375 (and by 25 for opacity)
// and resolve four quotient bits per stage. The front stages wrap and clamp the
// inputs, form p and the channel slope, weight each channel's hue segment, and
// scale to full range. Valid bits travel with the data and each stage advances on
// its own, so bubbles close up under back pressure and the input stays ready while
// empty stages remain. Inputs above range are wrapped (hue) or clamped to full.
`default_nettype none

module hsl_to_rgb_convert_unit import hrgb_pkg::*; #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [HUE_W-1:0]    hue_i,
  input  logic [PCT_W-1:0]    saturation_i,
  input  logic [PCT_W-1:0]    lightness_i,
  input  logic [PCT_W-1:0]    alpha_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUT_BITS-1:0] red_o,
  output logic [OUT_BITS-1:0] green_o,
  output logic [OUT_BITS-1:0] blue_o,
  output logic [OUT_BITS-1:0] opacity_o
);

  localparam int unsigned NSTG   = (OUT_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned QT_W   = NSTG * DIV_STEPS;
  localparam int unsigned NST    = 4 + NSTG;
  localparam int unsigned X_W    = W_W + OUT_BITS;
  localparam int unsigned XA_W   = PCT_W + OUT_BITS;
  localparam int unsigned YA_W   = XA_W - A_SHIFT;
  localparam int unsigned CACC_W = RGB_REM_W + QT_W;
  localparam int unsigned AACC_W = A_REM_W + QT_W;

  localparam logic [RGB_REM_W-1:0] RGB_REM_LIM = RGB_REM_W'(RGB_DIV);
  localparam logic [A_REM_W-1:0]   A_REM_LIM   = A_REM_W'(A_DIV);

  // ---------------------------------------------------------------- control
  logic [NST-1:0] vld_q;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NST-1];

  // ---------------------------------------------------------------- stage 1
  logic [HUE_W-1:0]  hue_w, t_red_raw;
  logic [HUE_W-1:0]  t_ch [3];
  logic [PCT_W-1:0]  sat_c, light_c, alpha_c;
  logic [M_W-1:0]    m_d;
  logic [XA_W-1:0]   xa;

  always_comb begin
    hue_w     = (hue_i >= HUE_TURN) ? hue_i - HUE_TURN : hue_i;
    t_red_raw = hue_w + HUE_THIRD;
    t_ch[0]   = (t_red_raw >= HUE_TURN) ? t_red_raw - HUE_TURN : t_red_raw;
    t_ch[1]   = hue_w;
    t_ch[2]   = (hue_w >= HUE_THIRD) ? hue_w - HUE_THIRD : hue_w + (HUE_TURN - HUE_THIRD);
    sat_c     = (saturation_i > PCT_FULL) ? PCT_FULL : saturation_i;
    light_c   = (lightness_i > PCT_FULL) ? PCT_FULL : lightness_i;
    alpha_c   = (alpha_i > PCT_FULL) ? PCT_FULL : alpha_i;
    // q - p is twice S * min(L, full - L), for either half of lightness.
    m_d       = (light_c < PCT_HALF) ? light_c[M_W-1:0] : M_W'(PCT_FULL - light_c);
    // alpha * (2^OUT_BITS - 1) plus half of 12800 for rounding.
    xa        = {alpha_c, OUT_BITS'(0)} - XA_W'(alpha_c) + XA_W'(PCT_HALF);
  end

  logic [PCT_W-1:0] sat1_q, light1_q;
  logic [M_W-1:0]   m1_q;
  logic [K_W-1:0]   k1_q [3];
  logic [YA_W-1:0]  ya1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sat1_q   <= sat_c;
      light1_q <= light_c;
      m1_q     <= m_d;
      for (int c = 0; c < 3; c++) begin
        k1_q[c] <= seg_weight(t_ch[c]);
      end
      ya1_q    <= xa[XA_W-1:A_SHIFT];
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [E_W-1:0]  e_d;
  logic [P_W-1:0]  lt_d;
  logic [E_W-1:0]  e2_q;
  logic [P_W-1:0]  p2_q;
  logic [K_W-1:0]  k2_q [3];
  logic [YA_W-1:0] ya2_q;

  assign e_d  = E_W'(sat1_q) * E_W'(m1_q);
  assign lt_d = P_W'(light1_q) * P_W'(PCT_FULL);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      e2_q  <= e_d;
      p2_q  <= lt_d - P_W'(e_d);
      k2_q  <= k1_q;
      ya2_q <= ya1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Half of the channel numerator: 480 * p + k * (q - p) / 2.
  logic [W_W-1:0]  w3_q [3];
  logic [YA_W-1:0] ya3_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int c = 0; c < 3; c++) begin
        w3_q[c] <= W_W'(p2_q) * W_W'(P_WEIGHT) + W_W'(k2_q[c]) * W_W'(e2_q);
      end
      ya3_q <= ya2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [X_W-1:0]    x_rgb [3];
  logic [CACC_W-1:0] cacc_q [NSTG+1][3];
  logic [AACC_W-1:0] aacc_q [NSTG+1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      x_rgb[c] = {w3_q[c], OUT_BITS'(0)} - X_W'(w3_q[c]) + X_W'(RGB_RND);
    end
  end

  // The dividend is below divisor * 2^OUT_BITS, so its bits above the quotient
  // field already form a valid starting remainder.
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int c = 0; c < 3; c++) begin
        cacc_q[0][c] <= CACC_W'(x_rgb[c][X_W-1:RGB_SHIFT]);
      end
      aacc_q[0] <= AACC_W'(ya3_q);
    end
  end

  // ---------------------------------------------------------------- divider stages
  for (genvar j = 1; j <= NSTG; j++) begin : g_div
    logic [CACC_W-1:0] cnext [3];
    logic [AACC_W-1:0] anext;

    for (genvar c = 0; c < 3; c++) begin : g_ch
      hrgb_cdiv_step #(
        .DIVISOR (RGB_DIV),
        .REM_W   (RGB_REM_W),
        .QT_W    (QT_W),
        .STEPS   (DIV_STEPS)
      ) u_rgb_div (
        .acc_i (cacc_q[j-1][c]),
        .acc_o (cnext[c])
      );
    end

    hrgb_cdiv_step #(
      .DIVISOR (A_DIV),
      .REM_W   (A_REM_W),
      .QT_W    (QT_W),
      .STEPS   (DIV_STEPS)
    ) u_alpha_div (
      .acc_i (aacc_q[j-1]),
      .acc_o (anext)
    );

    always_ff @(posedge clk_i) begin
      if (adv[3+j]) begin
        cacc_q[j] <= cnext;
        aacc_q[j] <= anext;
      end
    end
  end

  assign red_o     = cacc_q[NSTG][0][OUT_BITS-1:0];
  assign green_o   = cacc_q[NSTG][1][OUT_BITS-1:0];
  assign blue_o    = cacc_q[NSTG][2][OUT_BITS-1:0];
  assign opacity_o = aacc_q[NSTG][OUT_BITS-1:0];

  // ---------------------------------------------------------------- assertions
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &vld_q)
    else $error("input held off while a pipeline stage is empty");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && adv[1]) |=> vld_q[1])
    else $error("request lost between the first two stages");

  a_slope_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (m1_q <= M_W'(PCT_HALF)))
    else $error("lightness distance from the nearer end exceeds one half");

  a_start_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> ((cacc_q[0][0][CACC_W-1:QT_W] < RGB_REM_LIM) &&
                  (cacc_q[0][1][CACC_W-1:QT_W] < RGB_REM_LIM) &&
                  (cacc_q[0][2][CACC_W-1:QT_W] < RGB_REM_LIM) &&
                  (aacc_q[0][AACC_W-1:QT_W] < A_REM_LIM)))
    else $error("divider starting remainder not below its divisor");

endmodule

`default_nettype wire

[hdl/hrgb_cdiv_step.sv]
// STEPS restoring steps of a long division by a constant divisor.
// Standalone; instantiated once per lane in each divider stage of the converter.
`default_nettype none

module hrgb_cdiv_step #(
  parameter int unsigned DIVISOR = 9375,
  parameter int unsigned REM_W   = 14,
  parameter int unsigned QT_W    = 16,
  parameter int unsigned STEPS   = 4
) (
  input  logic [REM_W+QT_W-1:0] acc_i,
  output logic [REM_W+QT_W-1:0] acc_o
);

  localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

  // The upper field is the partial remainder; the lower field shifts dividend bits
  // out at the top while quotient bits enter at the bottom.
  always_comb begin : step_blk
    logic [REM_W-1:0] rem;
    logic [QT_W-1:0]  bits;
    logic [REM_W:0]   cand;
    rem  = acc_i[REM_W+QT_W-1:QT_W];
    bits = acc_i[QT_W-1:0];
    cand = '0;
    for (int i = 0; i < STEPS; i++) begin
      cand = {rem, bits[QT_W-1]};
      if (cand >= DIV_C) begin
        rem  = REM_W'(cand - DIV_C);
        bits = {bits[QT_W-2:0], 1'b1};
      end else begin
        rem  = cand[REM_W-1:0];
        bits = {bits[QT_W-2:0], 1'b0};
      end
    end
    acc_o = {rem, bits};
  end

endmodule

`default_nettype wire

[tb/sv/rgba_scoreboard.sv]
// Scoreboard for the HSLA to RGBA converter: watches the request and result channels,
// predicts each result and compares it field by field. Depends on hrgb_pkg.
`timescale 1ns / 100ps

module rgba_scoreboard import hrgb_pkg::*; #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [HUE_W-1:0]    hue_i,
  input  logic [PCT_W-1:0]    saturation_i,
  input  logic [PCT_W-1:0]    lightness_i,
  input  logic [PCT_W-1:0]    alpha_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OUT_BITS-1:0] red_i,
  input  logic [OUT_BITS-1:0] green_i,
  input  logic [OUT_BITS-1:0] blue_i,
  input  logic [OUT_BITS-1:0] opacity_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
    logic [OUT_BITS-1:0] opacity;
  } rgba_t;

  localparam longint unsigned FULL_SCALE = (64'd1 << OUT_BITS) - 64'd1;

  rgba_t       rgba_expected_q[$];
  rgba_t       want;
  int unsigned fail_count;
  int unsigned pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // p and q are in units of (1/128 percent) squared; returns the scaled channel level.
  function automatic longint unsigned channel_level(input longint unsigned p,
                                                    input longint unsigned q,
                                                    input longint unsigned t);
    longint unsigned k;
    longint unsigned den;
    longint unsigned v;
    den = 64'(PCT_FULL) * 64'(PCT_FULL) * 64'(HUE_SIXTH);
    if (t < HUE_SIXTH) begin
      k = t;
    end else if (t < HUE_HALF) begin
      k = 64'(HUE_SIXTH);
    end else if (t < HUE_TWO_THIRDS) begin
      k = 64'(HUE_TWO_THIRDS) - t;
    end else begin
      k = 0;
    end
    v = p * 64'(HUE_SIXTH) + k * (q - p);
    return (v * FULL_SCALE + den / 2) / den;
  endfunction

  function automatic rgba_t hsl_pixel_to_rgba(input logic [HUE_W-1:0] hue,
                                              input logic [PCT_W-1:0] sat,
                                              input logic [PCT_W-1:0] light,
                                              input logic [PCT_W-1:0] alpha);
    longint unsigned h, s, l, a, q, p, tr, tb;
    rgba_t           res;
    h = 64'(hue);
    s = (sat > PCT_FULL) ? 64'(PCT_FULL) : 64'(sat);
    l = (light > PCT_FULL) ? 64'(PCT_FULL) : 64'(light);
    a = (alpha > PCT_FULL) ? 64'(PCT_FULL) : 64'(alpha);
    if (h >= HUE_TURN) begin
      h = h - 64'(HUE_TURN);
    end
    if (2 * l < PCT_FULL) begin
      q = l * (64'(PCT_FULL) + s);
    end else begin
      q = l * 64'(PCT_FULL) + s * 64'(PCT_FULL) - l * s;
    end
    p = 2 * l * 64'(PCT_FULL) - q;
    tr = h + 64'(HUE_THIRD);
    if (tr >= HUE_TURN) begin
      tr = tr - 64'(HUE_TURN);
    end
    tb = (h >= HUE_THIRD) ? h - 64'(HUE_THIRD) : h + 64'(HUE_TURN) - 64'(HUE_THIRD);
    res.red     = OUT_BITS'(channel_level(p, q, tr));
    res.green   = OUT_BITS'(channel_level(p, q, h));
    res.blue    = OUT_BITS'(channel_level(p, q, tb));
    res.opacity = OUT_BITS'((a * FULL_SCALE + 64'(PCT_FULL) / 2) / 64'(PCT_FULL));
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [OUT_BITS-1:0] got,
                                 input logic [OUT_BITS-1:0] exp_val);
    $display("%0t ns: %s got %h, predicted %h", $time, field, got, exp_val);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgba_expected_q.delete();
      pending = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        rgba_expected_q.push_back(hsl_pixel_to_rgba(hue_i, saturation_i, lightness_i,
                                                    alpha_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (rgba_expected_q.size() == 0) begin
          report_mismatch("result with no request pending, red", red_i, '0);
        end else begin
          want = rgba_expected_q.pop_front();
          if (red_i !== want.red) begin
            report_mismatch("red", red_i, want.red);
          end
          if (green_i !== want.green) begin
            report_mismatch("green", green_i, want.green);
          end
          if (blue_i !== want.blue) begin
            report_mismatch("blue", blue_i, want.blue);
          end
          if (opacity_i !== want.opacity) begin
            report_mismatch("opacity", opacity_i, want.opacity);
          end
        end
      end
      pending = rgba_expected_q.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the HSLA to RGBA converter testbench: clock, reset, pixel requests and
// result back pressure, and the verdict. Depends on hrgb_pkg and rgba_scoreboard.
`timescale 1ns / 100ps

module testbench;
  import hrgb_pkg::*;

  localparam int unsigned OUT_BITS     = 16;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned QUIET_ITEMS  = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 64;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic [HUE_W-1:0]    hue_i        = '0;
  logic [PCT_W-1:0]    saturation_i = '0;
  logic [PCT_W-1:0]    lightness_i  = '0;
  logic [PCT_W-1:0]    alpha_i      = '0;
  logic                out_ready_i  = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [OUT_BITS-1:0] red_o;
  logic [OUT_BITS-1:0] green_o;
  logic [OUT_BITS-1:0] blue_o;
  logic [OUT_BITS-1:0] opacity_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned hold_req    = 0;
  int unsigned holds_done  = 0;
  bit          idle_off    = 1'b0;

  hsl_to_rgb_convert_unit #(
    .OUT_BITS(OUT_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .lightness_i (lightness_i),
    .alpha_i     (alpha_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .opacity_o   (opacity_o)
  );

  rgba_scoreboard #(
    .OUT_BITS(OUT_BITS)
  ) u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .lightness_i (lightness_i),
    .alpha_i     (alpha_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_i       (red_o),
    .green_i     (green_o),
    .blue_i      (blue_o),
    .opacity_i   (opacity_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever the request side asks.
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (holds_done < hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end else if (idle_off || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic offer_pixel(input logic [HUE_W-1:0] h, input logic [PCT_W-1:0] s,
                             input logic [PCT_W-1:0] l, input logic [PCT_W-1:0] a,
                             input bit allow_gap);
    if (allow_gap && !idle_off && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    lightness_i  <= l;
    alpha_i      <= a;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [HUE_W-1:0] hue_on_boundary();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return HUE_W'(HUE_SIXTH - 1);
      2: return HUE_SIXTH;
      3: return HUE_W'(HUE_HALF - 1);
      4: return HUE_HALF;
      5: return HUE_W'(HUE_TWO_THIRDS - 1);
      6: return HUE_TWO_THIRDS;
      default: return HUE_W'(HUE_TURN - 1);
    endcase
  endfunction

  initial begin
    logic [HUE_W-1:0] h;
    logic [PCT_W-1:0] s;
    logic [PCT_W-1:0] l;
    logic [PCT_W-1:0] a;
    bit               no_gap;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Segment edges, grey pixels, out-of-range hue and clamped percentages.
    offer_pixel(13'd0,    14'd0,     14'd0,     14'd0,     1'b1);
    offer_pixel(13'd0,    14'd12800, 14'd6400,  14'd12800, 1'b1);
    offer_pixel(13'd959,  14'd12800, 14'd6400,  14'd1,     1'b1);
    offer_pixel(13'd960,  14'd12800, 14'd3200,  14'd6400,  1'b1);
    offer_pixel(13'd2879, 14'd6000,  14'd9000,  14'd12799, 1'b1);
    offer_pixel(13'd2880, 14'd12800, 14'd6399,  14'd100,   1'b1);
    offer_pixel(13'd3839, 14'd12800, 14'd6400,  14'd200,   1'b1);
    offer_pixel(13'd3840, 14'd9000,  14'd12800, 14'd300,   1'b1);
    offer_pixel(13'd5759, 14'd12800, 14'd12799, 14'd12800, 1'b1);
    offer_pixel(13'd5760, 14'd12800, 14'd6400,  14'd16383, 1'b1);
    offer_pixel(13'd8191, 14'd16383, 14'd16383, 14'd16383, 1'b1);
    offer_pixel(13'd1920, 14'd0,     14'd5000,  14'd8000,  1'b1);
    offer_pixel(13'd4000, 14'd0,     14'd12800, 14'd0,     1'b1);
    offer_pixel(13'd1919, 14'd11111, 14'd1,     14'd4000,  1'b1);
    offer_pixel(13'd3000, 14'd16383, 14'd7000,  14'd12800, 1'b1);
    offer_pixel(13'd100,  14'd5000,  14'd16383, 14'd7000,  1'b1);
    offer_pixel(13'd6000, 14'd8000,  14'd3000,  14'd15000, 1'b1);
    offer_pixel(13'd1000, 14'd10922, 14'd8191,  14'd8191,  1'b1);
    offer_pixel(13'd4095, 14'd5461,  14'd5461,  14'd10922, 1'b1);
    offer_pixel(13'd7680, 14'd12800, 14'd6400,  14'd9999,  1'b1);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // Two windows of back-to-back requests while the result side holds off.
      if (i == 300 || i == 900) begin
        hold_req++;
      end
      no_gap = (i >= 300 && i < 400) || (i >= 900 && i < 1000);
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        idle_off = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: begin
          h = HUE_W'($urandom_range(0, 8191));
          s = PCT_W'($urandom_range(0, 16383));
          l = PCT_W'($urandom_range(0, 16383));
          a = PCT_W'($urandom_range(0, 16383));
        end
        1, 2: begin
          h = hue_on_boundary();
          s = ($urandom_range(0, 1) != 0) ? PCT_FULL : '0;
          case ($urandom_range(0, 3))
            0: l = '0;
            1: l = PCT_W'(PCT_HALF - 1);
            2: l = PCT_HALF;
            default: l = PCT_FULL;
          endcase
          a = ($urandom_range(0, 1) != 0) ? PCT_FULL : PCT_W'($urandom_range(0, 12800));
        end
        default: begin
          h = HUE_W'($urandom_range(0, 5759));
          s = PCT_W'($urandom_range(0, 12800));
          l = PCT_W'($urandom_range(0, 12800));
          a = PCT_W'($urandom_range(0, 12800));
        end
      endcase
      offer_pixel(h, s, l, a, !no_gap);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
